### rtl/rmed_pkg.sv
// shared types and constants for the multichannel running median filter
`timescale 1ns / 1ps

package rmed_pkg;

  localparam int unsigned WINDOW_DEF      = 5;
  localparam int unsigned CHANNELS_DEF    = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  localparam int unsigned CH_BITS   = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned MASK_BITS = 8;

  typedef struct packed {
    logic                valid;
    logic                in_range;
    logic [CH_BITS-1:0]  ch;
  } item_ctrl_t;

endpackage

### rtl/rmed_ram.sv
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps

module rmed_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rmed_hist.sv
// per-channel sample history: ram read, forwarding, window shift and write-back
`timescale 1ns / 1ps

module rmed_hist #(
  parameter int unsigned WINDOW      = rmed_pkg::WINDOW_DEF,
  parameter int unsigned CHANNELS    = rmed_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = rmed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  logic                                  in_valid_i,
  input  logic [rmed_pkg::CH_BITS-1:0]          in_ch_i,
  input  logic [SAMPLE_BITS-1:0]                in_sample_i,
  output rmed_pkg::item_ctrl_t                  out_ctrl_o,
  output logic [WINDOW-1:0][SAMPLE_BITS-1:0]    out_vals_o
);

  import rmed_pkg::*;

  localparam int unsigned HIST     = WINDOW - 1;
  localparam int unsigned AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SLOTS    = 1 << AW;
  localparam int unsigned ROW_BITS = HIST * SAMPLE_BITS;

  typedef logic [HIST-1:0][SAMPLE_BITS-1:0] row_t;

  item_ctrl_t                          s1_ctrl_q, s1_ctrl_d;
  logic [SAMPLE_BITS-1:0]              s1_sample_q;
  logic [AW-1:0]                       rd_addr, s1_addr;
  logic [ROW_BITS-1:0]                 rd_data;
  row_t                                rd_row, old_row, new_row;
  logic                                we;
  logic                                fwd_valid_q;
  logic [AW-1:0]                       fwd_addr_q;
  row_t                                fwd_row_q;
  logic [SLOTS-1:0]                    valid_q;
  item_ctrl_t                          s2_ctrl_q;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  s2_vals_q, s2_vals_d;

  assign rd_addr = AW'(in_ch_i);
  assign s1_addr = AW'(s1_ctrl_q.ch);
  assign rd_row  = rd_data;

  always_comb begin
    s1_ctrl_d.valid    = in_valid_i;
    s1_ctrl_d.in_range = int'(in_ch_i) < CHANNELS;
    s1_ctrl_d.ch       = in_ch_i;
  end

  rmed_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_addr),
    .wdata_i (new_row),
    .re_i    (adv_i && in_valid_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // newest copy of the channel window: last write, stored row, or reset zeros
  always_comb begin
    old_row = '0;
    if (s1_ctrl_q.in_range) begin
      if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
        old_row = fwd_row_q;
      end else if (valid_q[s1_addr]) begin
        old_row = rd_row;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < HIST - 1; i++) begin
      new_row[i] = old_row[i+1];
    end
    new_row[HIST-1] = s1_sample_q;
    for (int i = 0; i < HIST; i++) begin
      s2_vals_d[i] = old_row[i];
    end
    s2_vals_d[HIST] = s1_sample_q;
  end

  assign we = adv_i && s1_ctrl_q.valid && s1_ctrl_q.in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q   <= '0;
      s2_ctrl_q   <= '0;
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      valid_q     <= '0;
    end else begin
      if (adv_i) begin
        s1_ctrl_q <= s1_ctrl_d;
        s2_ctrl_q <= s1_ctrl_q;
      end
      if (we) begin
        fwd_valid_q      <= 1'b1;
        fwd_addr_q       <= s1_addr;
        valid_q[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_sample_q <= in_sample_i;
      s2_vals_q   <= s2_vals_d;
    end
    if (we) begin
      fwd_row_q <= new_row;
    end
  end

  assign out_ctrl_o = s2_ctrl_q;
  assign out_vals_o = s2_vals_q;

  // a channel once written never falls back to its reset window
  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & $past(valid_q)) == $past(valid_q))
    else $error("history valid bit cleared");

  // the forward register tracks the last written channel
  a_fwd_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> fwd_valid_q && (fwd_addr_q == $past(s1_addr)) && valid_q[fwd_addr_q])
    else $error("forward register lost last write");

endmodule

### rtl/rmed_sort.sv
// rank-based median selection: pairwise compare stage, then rank and pick stage
`timescale 1ns / 1ps

module rmed_sort #(
  parameter int unsigned WINDOW      = rmed_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = rmed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  rmed_pkg::item_ctrl_t                in_ctrl_i,
  input  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  in_vals_i,
  output rmed_pkg::item_ctrl_t                out_ctrl_o,
  output logic [SAMPLE_BITS-1:0]              lo_o,
  output logic [SAMPLE_BITS-1:0]              hi_o
);

  import rmed_pkg::*;

  localparam int MID_LO = (WINDOW - 1) / 2;
  localparam int MID_HI = WINDOW / 2;

  item_ctrl_t                          s3_ctrl_q, s4_ctrl_q;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  s3_vals_q;
  logic [WINDOW-1:0][WINDOW-1:0]       before_q, before_d;
  logic [WINDOW-1:0]                   sel_lo, sel_hi;
  logic [SAMPLE_BITS-1:0]              lo_d, hi_d, lo_q, hi_q;

  // before[i][j]: sample j sorts ahead of sample i, ties broken by position
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      for (int j = 0; j < WINDOW; j++) begin
        if (j < i) begin
          before_d[i][j] = $signed(in_vals_i[j]) <= $signed(in_vals_i[i]);
        end else if (j > i) begin
          before_d[i][j] = $signed(in_vals_i[j]) < $signed(in_vals_i[i]);
        end else begin
          before_d[i][j] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    lo_d = '0;
    hi_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      sel_lo[i] = $countones(before_q[i]) == MID_LO;
      sel_hi[i] = $countones(before_q[i]) == MID_HI;
      if (sel_lo[i]) begin
        lo_d = s3_vals_q[i];
      end
      if (sel_hi[i]) begin
        hi_d = s3_vals_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_ctrl_q <= '0;
      s4_ctrl_q <= '0;
    end else if (adv_i) begin
      s3_ctrl_q <= in_ctrl_i;
      s4_ctrl_q <= s3_ctrl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_vals_q <= in_vals_i;
      before_q  <= before_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
    end
  end

  assign out_ctrl_o = s4_ctrl_q;
  assign lo_o       = lo_q;
  assign hi_o       = hi_q;

  // ranks form a permutation, so each middle rank is held by exactly one sample
  a_rank_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_ctrl_q.valid |-> $onehot(sel_lo) && $onehot(sel_hi))
    else $error("median rank not unique");

  a_mid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_ctrl_q.valid |-> $signed(lo_q) <= $signed(hi_q))
    else $error("middle values out of order");

endmodule

### rtl/multichannel_running_median5_unit.sv
// top level of the multichannel running median filter
`timescale 1ns / 1ps

// Running median over the last WINDOW samples of each of CHANNELS channels.
// Input transaction: s_axis_tuser carries the channel, s_axis_tdata the
// signed sample (low SAMPLE_BITS bits used). Output transaction: m_axis_tuser
// echoes the channel, m_axis_tdata the signed median, sign-extended.
// cfg_we_i/cfg_wdata_i write the clamp mask: bit c forces a negative median
// on channel c to zero. Write it only while no transaction is in flight.
// Pipeline: history read, window build, pairwise compare, rank and pick, then
// the output register. Throughput: one transaction per cycle when not stalled,
// any channel order, including the same channel back to back; the history row
// written by one item is forwarded to the next, so the history ram sets no limit.
// Stall: the whole pipe holds while the output register is full and
// m_axis_tready is low; s_axis_tready follows from that.
// Reset: all channel windows read as zero until first written (one valid
// bit per channel), the mask clears, no result is pending. No clearing pass.
// Channels at or above CHANNELS leave the history alone and return zero.
module multichannel_running_median5_unit #(
  parameter int unsigned WINDOW      = rmed_pkg::WINDOW_DEF,
  parameter int unsigned CHANNELS    = rmed_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = rmed_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmed_pkg::MASK_BITS-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rmed_pkg::DATA_BITS-1:0]    s_axis_tdata,  // [31:0] sample
  input  logic [rmed_pkg::CH_BITS-1:0]      s_axis_tuser,  // [2:0] channel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rmed_pkg::DATA_BITS-1:0]    m_axis_tdata,  // [31:0] median
  output logic [rmed_pkg::CH_BITS-1:0]      m_axis_tuser   // [2:0] out_channel
);

  import rmed_pkg::*;

  logic                                adv;
  logic [MASK_BITS-1:0]                clamp_mask_q;
  item_ctrl_t                          s2_ctrl, s4_ctrl;
  logic [WINDOW-1:0][SAMPLE_BITS-1:0]  s2_vals;
  logic [SAMPLE_BITS-1:0]              lo, hi;
  logic [SAMPLE_BITS:0]                sum, adj;
  logic [SAMPLE_BITS-1:0]              half;
  logic signed [DATA_BITS-1:0]         med_full;
  logic [DATA_BITS-1:0]                out_med_d, out_med_q;
  logic [CH_BITS-1:0]                  out_ch_q;
  logic                                out_valid_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_mask_q <= '0;
    end else if (cfg_we_i) begin
      clamp_mask_q <= cfg_wdata_i;
    end
  end

  rmed_hist #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (s_axis_tvalid),
    .in_ch_i     (s_axis_tuser),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .out_ctrl_o  (s2_ctrl),
    .out_vals_o  (s2_vals)
  );

  rmed_sort #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sort (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_ctrl_i  (s2_ctrl),
    .in_vals_i  (s2_vals),
    .out_ctrl_o (s4_ctrl),
    .lo_o       (lo),
    .hi_o       (hi)
  );

  // mean of the two middle values, truncated toward zero
  always_comb begin
    sum      = {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi};
    adj      = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]};
    half     = adj[SAMPLE_BITS:1];
    med_full = DATA_BITS'($signed(half));
    out_med_d = med_full;
    if (!s4_ctrl.in_range) begin
      out_med_d = '0;
    end else if (med_full[DATA_BITS-1] && clamp_mask_q[s4_ctrl.ch]) begin
      out_med_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s4_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ch_q  <= s4_ctrl.ch;
      out_med_q <= out_med_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_med_q;
  assign m_axis_tuser  = out_ch_q;

  a_unused_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (int'(out_ch_q) >= CHANNELS) |-> out_med_q == '0)
    else $error("unused channel gave a non-zero median");

endmodule

### bench/multichannel_running_median5_unit_test.sv
// self-checking testbench for the multichannel running median filter
`timescale 1ns / 1ps

typedef struct packed {
  logic [rmed_pkg::CH_BITS-1:0]          ch;
  logic signed [rmed_pkg::DATA_BITS-1:0] med;
} median_result_t;

class median_scoreboard;
  localparam int unsigned DEPTH = rmed_pkg::WINDOW_DEF - 1;

  bit signed [rmed_pkg::DATA_BITS-1:0] window_hist [rmed_pkg::CHANNELS_DEF][DEPTH];
  bit [rmed_pkg::MASK_BITS-1:0]        clamp_mask;
  median_result_t                      pending_medians [$];
  int                                  error_count;

  function new();
    foreach (window_hist[c, i]) window_hist[c][i] = '0;
    clamp_mask  = '0;
    error_count = 0;
  endfunction

  // work out the median that an accepted sample must produce
  function void note_sample(logic [rmed_pkg::CH_BITS-1:0] ch,
                            logic [rmed_pkg::DATA_BITS-1:0] smp);
    bit signed [rmed_pkg::DATA_BITS-1:0] win [rmed_pkg::WINDOW_DEF];
    bit signed [rmed_pkg::DATA_BITS-1:0] tmp;
    median_result_t                      res;
    for (int i = 0; i < DEPTH; i++) win[i] = window_hist[ch][i];
    win[DEPTH] = smp;
    for (int i = 0; i < DEPTH; i++) window_hist[ch][i] = win[i+1];
    for (int i = 0; i < rmed_pkg::WINDOW_DEF - 1; i++) begin
      for (int j = 0; j < rmed_pkg::WINDOW_DEF - 1 - i; j++) begin
        if (win[j] > win[j+1]) begin
          tmp      = win[j];
          win[j]   = win[j+1];
          win[j+1] = tmp;
        end
      end
    end
    res.ch  = ch;
    res.med = win[rmed_pkg::WINDOW_DEF / 2];
    if (res.med < 0 && clamp_mask[ch]) res.med = '0;
    pending_medians.push_back(res);
  endfunction

  function void check_median(logic [rmed_pkg::CH_BITS-1:0] ch,
                             logic [rmed_pkg::DATA_BITS-1:0] med);
    median_result_t want;
    if (pending_medians.size() == 0) begin
      $display("%0t: unexpected result channel %0d median %0d", $time, ch, $signed(med));
      error_count++;
    end else begin
      want = pending_medians.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: channel mismatch, expected %0d, actual %0d", $time, want.ch, ch);
        error_count++;
      end
      if (want.med !== med) begin
        $display("%0t: median mismatch on channel %0d, expected %0d, actual %0d",
                 $time, want.ch, want.med, $signed(med));
        error_count++;
      end
    end
  endfunction

  function int outstanding();
    return pending_medians.size();
  endfunction
endclass

module multichannel_running_median5_unit_test;
  import rmed_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 80;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [MASK_BITS-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_BITS-1:0] s_axis_tdata  = '0;
  logic [CH_BITS-1:0]   s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_BITS-1:0] m_axis_tdata;
  logic [CH_BITS-1:0]   m_axis_tuser;

  median_scoreboard sb = new();
  int unsigned      cycle_count = 0;
  bit               idling_on   = 1'b1;
  bit               hold_req    = 1'b0;
  logic [CH_BITS-1:0] last_ch   = '0;

  multichannel_running_median5_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // transaction monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_median(m_axis_tuser, m_axis_tdata);
    end
  end

  // result sink with random back-pressure and one long hold-off
  initial begin : sink
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [CH_BITS-1:0] ch, input logic [DATA_BITS-1:0] smp);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (sb.outstanding() != 0);
    @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [MASK_BITS-1:0] m);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.clamp_mask = m;
  endtask

  function automatic logic [DATA_BITS-1:0] pick_sample();
    logic [DATA_BITS-1:0] corner [6];
    int unsigned          mode;
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
               32'h8000_0001, 32'h7fff_fffe};
    mode = $urandom_range(0, 9);
    if (mode < 4) return $urandom;
    if (mode < 8) return 32'($signed($urandom_range(0, 200)) - 100);
    if (mode == 8) return corner[$urandom_range(0, 5)];
    return corner[$urandom_range(0, 1)] ^ 32'($urandom_range(0, 15));
  endfunction

  // random transactions, bursts on one channel mixed with hopping
  task automatic run_phase(input int unsigned count, input bit with_hold);
    int unsigned no_gap_left;
    no_gap_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (with_hold && n == 50) begin
        hold_req    = 1'b1;
        no_gap_left = 40;
      end
      if (no_gap_left > 0) no_gap_left--;
      else if (idling_on && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 10));
      if ($urandom_range(0, 9) >= 4) last_ch = CH_BITS'($urandom_range(0, CHANNELS_DEF - 1));
      send_sample(last_ch, pick_sample());
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes back to back on channel 0, then channel 7 and each other channel; windows start from zeros
    repeat (3) send_sample(3'd0, 32'h7fff_ffff);
    repeat (3) send_sample(3'd0, 32'h8000_0000);
    send_sample(3'd0, 32'hffff_ffff);
    send_sample(3'd0, 32'h0);
    send_sample(3'd0, 32'h1);
    repeat (3) send_sample(3'd7, 32'hffff_fffb);
    for (int c = 1; c < 7; c++) send_sample(CH_BITS'(c), 32'(c));

    // negative medians clamped on every channel
    write_mask(8'hff);
    send_sample(3'd7, 32'hffff_fffb);
    repeat (3) send_sample(3'd0, 32'h8000_0000);
    send_sample(3'd1, 32'h8000_0000);
    send_sample(3'd1, 32'h7fff_ffff);

    run_phase(300, 1'b1);
    write_mask(MASK_BITS'($urandom));
    run_phase(300, 1'b0);
    write_mask(8'h00);
    run_phase(300, 1'b0);
    write_mask(8'h5a);
    run_phase(300, 1'b0);
    write_mask(MASK_BITS'($urandom));
    idling_on = 1'b0;
    run_phase(200, 1'b0);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
